/* src/lfdc_pkg.sv */
// Package for the line-follow drive controller: payload and state types,
// register indexes, duty constants and the percent scaling function.
// Depends on nothing; every other file of the block imports it.
package lfdc_pkg;

   localparam logic [8:0] DUTY_STRAIGHT = 9'd335;
   localparam logic [8:0] DUTY_JUNCTION = 9'd215;
   localparam logic [8:0] DUTY_CURVE_HI = 9'd245;
   localparam logic [8:0] DUTY_CURVE_LO = 9'd155;
   localparam logic [8:0] DUTY_SPIN     = 9'd195;

   // Division by 100 as a multiply by a rounded-up reciprocal. Exact for
   // every product below 43690, which covers the largest duty above times
   // the largest 7-bit percent.
   localparam logic [15:0] RECIP_100   = 16'd41944;
   localparam int          RECIP_SHIFT = 22;

   localparam logic [7:0] RUN_MAX = 8'hFF;

   // Register reset values.
   localparam logic [9:0] DARK_THRESHOLD_RST   = 10'd550;
   localparam logic [7:0] DARK_CONFIRM_RST     = 8'd8;
   localparam logic [7:0] LIGHT_CONFIRM_RST    = 8'd20;
   localparam logic [3:0] JUNCTION_CONFIRM_RST = 4'd3;
   localparam logic [7:0] LOST_LIMIT_RST       = 8'd5;
   localparam logic [6:0] TUNNEL_SCALE_RST     = 7'd88;
   localparam logic [9:0] TUNNEL_TRIM_RST      = 10'd25;

   typedef enum logic [2:0] {
      CSR_DARK_THRESHOLD   = 3'd0,
      CSR_DARK_CONFIRM     = 3'd1,
      CSR_LIGHT_CONFIRM    = 3'd2,
      CSR_JUNCTION_CONFIRM = 3'd3,
      CSR_LOST_LIMIT       = 3'd4,
      CSR_TUNNEL_SCALE     = 3'd5,
      CSR_TUNNEL_TRIM      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [9:0] light_level;
      logic       left_line_raw;
      logic       right_line_raw;
   } req_type;

   typedef struct packed {
      logic [9:0] left_duty;
      logic [9:0] right_duty;
      logic       drive_mode;
      logic       tunnel_flag;
   } rsp_type;

   // Configuration as the step logic sees it. The tunnel percent is kept
   // only in the form of the four duties it produces.
   typedef struct packed {
      logic [9:0] dark_threshold;
      logic [7:0] dark_confirm;
      logic [7:0] light_confirm;
      logic [3:0] junction_confirm;
      logic [7:0] lost_limit;
      logic [9:0] tunnel_trim;
      logic [8:0] scaled_straight;
      logic [8:0] scaled_junction;
      logic [8:0] scaled_curve_hi;
      logic [8:0] scaled_curve_lo;
   } cfg_type;

   typedef struct packed {
      logic [7:0] dark_run;
      logic [7:0] light_run;
      logic       inside_tunnel;
      logic [3:0] junction_run;
      logic [7:0] lost_run;
      logic       searching;
   } state_type;

   // Called with a constant duty, so the product is a constant multiply.
   function automatic logic [8:0] scale_duty(input logic [8:0] duty,
                                             input logic [6:0] pct);
      logic [15:0] prod;
      logic [31:0] quo;
      prod = 16'(duty) * 16'(pct);
      quo  = 32'(prod) * 32'(RECIP_100);
      return 9'(quo >> RECIP_SHIFT);
   endfunction

endpackage

/* src/lfdc_step.sv */
// Per-tick update of the line-follow drive controller: next state and the
// result item for one accepted input. Purely combinational.
// Depends on lfdc_pkg.
module lfdc_step
   import lfdc_pkg::*;
(
   input  req_type   req,
   input  state_type state_cur,
   input  cfg_type   cfg,
   output state_type state_nxt,
   output rsp_type   rsp
);

   logic       left_seen;
   logic       right_seen;
   logic [7:0] lost_inc;
   logic       spin;
   logic [8:0] raw_l;
   logic [8:0] raw_r;
   logic [8:0] scl_l;
   logic [8:0] scl_r;
   logic [8:0] out_l;
   logic [8:0] out_r;
   logic [3:0] junc_inc;

   always_comb begin
      left_seen  = ~req.left_line_raw;
      right_seen = ~req.right_line_raw;
      state_nxt = state_cur;
      spin      = 1'b0;
      raw_l     = DUTY_STRAIGHT;
      raw_r     = DUTY_STRAIGHT;
      scl_l     = cfg.scaled_straight;
      scl_r     = cfg.scaled_straight;
      lost_inc  = (state_cur.lost_run != RUN_MAX) ? state_cur.lost_run + 8'd1
                                                   : state_cur.lost_run;
      junc_inc  = (state_cur.junction_run < cfg.junction_confirm)
                  ? state_cur.junction_run + 4'd1 : state_cur.junction_run;

      if (state_cur.searching && !left_seen && !right_seen) begin
         // Still lost while searching: keep spinning, freeze everything.
         spin = 1'b1;
      end else begin
         state_nxt.searching = 1'b0;
         if (state_cur.searching) begin
            state_nxt.lost_run = '0;
         end

         if (req.light_level < cfg.dark_threshold) begin
            if (state_cur.dark_run != RUN_MAX) begin
               state_nxt.dark_run = state_cur.dark_run + 8'd1;
            end
            state_nxt.light_run = '0;
         end else begin
            if (state_cur.light_run != RUN_MAX) begin
               state_nxt.light_run = state_cur.light_run + 8'd1;
            end
            state_nxt.dark_run = '0;
         end
         if (state_nxt.dark_run >= cfg.dark_confirm) begin
            state_nxt.inside_tunnel = 1'b1;
         end
         if (state_nxt.light_run >= cfg.light_confirm) begin
            state_nxt.inside_tunnel = 1'b0;
         end

         if (left_seen && right_seen) begin
            state_nxt.junction_run = junc_inc;
            state_nxt.lost_run     = '0;
            if (junc_inc >= cfg.junction_confirm) begin
               raw_l = DUTY_JUNCTION;
               raw_r = DUTY_JUNCTION;
               scl_l = cfg.scaled_junction;
               scl_r = cfg.scaled_junction;
            end
         end else begin
            state_nxt.junction_run = '0;
            if (left_seen) begin
               state_nxt.lost_run = '0;
               raw_l = DUTY_CURVE_LO;
               raw_r = DUTY_CURVE_HI;
               scl_l = cfg.scaled_curve_lo;
               scl_r = cfg.scaled_curve_hi;
            end else if (right_seen) begin
               state_nxt.lost_run = '0;
               raw_l = DUTY_CURVE_HI;
               raw_r = DUTY_CURVE_LO;
               scl_l = cfg.scaled_curve_hi;
               scl_r = cfg.scaled_curve_lo;
            end else if (lost_inc < cfg.lost_limit) begin
               state_nxt.lost_run = lost_inc;
            end else begin
               state_nxt.searching = 1'b1;
               state_nxt.lost_run  = '0;
               spin                = 1'b1;
            end
         end
      end

      // Tunnel scaling, then the right trim when both duties came out equal.
      out_l = raw_l;
      out_r = raw_r;
      if (state_nxt.inside_tunnel) begin
         out_l = scl_l;
         out_r = scl_r;
         if (scl_l == scl_r && 10'(scl_r) > cfg.tunnel_trim) begin
            out_r = 9'(10'(scl_r) - cfg.tunnel_trim);
         end
      end

      rsp.tunnel_flag = state_nxt.inside_tunnel;
      if (spin) begin
         rsp.left_duty  = 10'(DUTY_SPIN);
         rsp.right_duty = 10'(DUTY_SPIN);
         rsp.drive_mode = 1'b1;
      end else begin
         rsp.left_duty  = 10'(out_l);
         rsp.right_duty = 10'(out_r);
         rsp.drive_mode = 1'b0;
      end
   end

endmodule

/* src/line_follow_drive_controller.sv */
// Top level of the line-follow drive controller: configuration registers,
// tick state, result register and skid stage. Depends on lfdc_pkg and
// lfdc_step.

// Usage. Each transfer on the req_ channel is one control tick: a light
// sample and the two line-sensor levels (0 means on the line). Each tick
// produces exactly one transfer on the rsp_ channel with the two wheel
// duties, the drive mode (spin search or forward) and the tunnel flag.
// The csr_ channel writes one of the seven registers by index; it is always
// ready, and an index past the last register is accepted and ignored.
// Registers should be written only while no tick is in flight.
//
// A tick's result is registered, in the skid stage if the receiver stalls.
// Throughput is one tick per cycle while the receiver keeps up; the whole
// tick update is a single combinational pass from the state registers to
// the result register. The tunnel-scaled duties are worked out when the
// percent register is written, so a tick needs only a compare and a trim.
//
// Reset clears all tick state and both output stages, and loads every
// register with its default. When the receiver stalls, the result register
// holds and one more tick is still taken into the skid stage; req_ready
// then drops until the stall clears.
module line_follow_drive_controller
   import lfdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   rsp_type   step_rsp;
   rsp_type   out_ff;
   rsp_type   out_in;
   rsp_type   skid_ff;
   rsp_type   skid_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      skid_valid_ff;
   logic      skid_valid_in;
   logic      req_fire;
   logic      rsp_fire;

   assign csr_ready = 1'b1;
   assign req_ready = ~skid_valid_ff;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = out_valid_ff & rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // Register writes. A percent write refreshes the four scaled duties.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DARK_THRESHOLD:   cfg_in.dark_threshold   = csr_wdata;
            CSR_DARK_CONFIRM:     cfg_in.dark_confirm     = csr_wdata[7:0];
            CSR_LIGHT_CONFIRM:    cfg_in.light_confirm    = csr_wdata[7:0];
            CSR_JUNCTION_CONFIRM: cfg_in.junction_confirm = csr_wdata[3:0];
            CSR_LOST_LIMIT:       cfg_in.lost_limit       = csr_wdata[7:0];
            CSR_TUNNEL_SCALE: begin
               cfg_in.scaled_straight = scale_duty(DUTY_STRAIGHT, csr_wdata[6:0]);
               cfg_in.scaled_junction = scale_duty(DUTY_JUNCTION, csr_wdata[6:0]);
               cfg_in.scaled_curve_hi = scale_duty(DUTY_CURVE_HI, csr_wdata[6:0]);
               cfg_in.scaled_curve_lo = scale_duty(DUTY_CURVE_LO, csr_wdata[6:0]);
            end
            CSR_TUNNEL_TRIM:      cfg_in.tunnel_trim      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dark_threshold   <= DARK_THRESHOLD_RST;
         cfg_ff.dark_confirm     <= DARK_CONFIRM_RST;
         cfg_ff.light_confirm    <= LIGHT_CONFIRM_RST;
         cfg_ff.junction_confirm <= JUNCTION_CONFIRM_RST;
         cfg_ff.lost_limit       <= LOST_LIMIT_RST;
         cfg_ff.tunnel_trim      <= TUNNEL_TRIM_RST;
         cfg_ff.scaled_straight  <= scale_duty(DUTY_STRAIGHT, TUNNEL_SCALE_RST);
         cfg_ff.scaled_junction  <= scale_duty(DUTY_JUNCTION, TUNNEL_SCALE_RST);
         cfg_ff.scaled_curve_hi  <= scale_duty(DUTY_CURVE_HI, TUNNEL_SCALE_RST);
         cfg_ff.scaled_curve_lo  <= scale_duty(DUTY_CURVE_LO, TUNNEL_SCALE_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // One tick update per accepted transfer.
   lfdc_step u_step (
      .req       (req_payload),
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register plus skid stage. A new result goes straight to the
   // result register unless that register still holds one that is not
   // being taken this cycle; then it waits in the skid stage.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = step_rsp;
            out_valid_in = req_fire;
         end
      end else if (req_fire) begin
         if (out_valid_ff) begin
            skid_in       = step_rsp;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* src/lfdc_checker.sv */
// Port-level checks for the line-follow drive controller, and the bind
// that attaches them to the top level. Depends on lfdc_pkg.
module lfdc_checker
   import lfdc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result withdrawn");

   // A stalled result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled result changed");

   // The search always spins at the fixed duty, never scaled or trimmed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.drive_mode |->
         rsp_payload.left_duty == 10'(DUTY_SPIN) &&
         rsp_payload.right_duty == 10'(DUTY_SPIN))
      else $error("spin result with wrong duties");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Input back-pressure only while a result is waiting downstream.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind line_follow_drive_controller lfdc_checker u_lfdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
